// File: src/rdd_pkg.sv
// Package for the reversible deque drop engine.
// Holds function and status codes, field widths and the control state type.
// No dependencies.
`default_nettype none

package rdd_pkg;

    // Payload widths fixed by the item format
    localparam int unsigned VAL_W = 8;

    // Function code of an input item
    typedef enum logic [1:0] {
        FN_PUSH    = 2'd0,
        FN_REVERSE = 2'd1,
        FN_DROP    = 2'd2,
        FN_FINISH  = 2'd3
    } t_func;

    // Status code of a result item
    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ERROR    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Control state: accept commands, or drain the store
    typedef enum logic [0:0] {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

endpackage

`default_nettype wire

// File: src/rdd_if.sv
// Valid/ready channel interfaces of the deque engine: command items in,
// result items out. Depends on rdd_pkg.
`default_nettype none

interface rdd_in_if;
    import rdd_pkg::*;

    logic               valid;
    logic               ready;
    t_func              func;
    logic [VAL_W-1:0]   value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface rdd_out_if;
    import rdd_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [VAL_W-1:0]   value_res;
    logic               last;

    modport source (output valid, output status, output value_res, output last,
                    input ready);
    modport sink   (input valid, input status, input value_res, input last,
                    output ready);
endinterface

`default_nettype wire

// File: src/rdd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module rdd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/reversible_deque_drop_engine.sv
// Reversible deque drop engine: ring-buffer deque in one RAM, with direction flag.
// Push, reverse and drop give no result item.
// Finish with a stored list drains one element per cycle unless the output stalls,
// through a RAM read, then the output register; the RAM read port sets that rate.
// Finish on an empty store or after an error or overflow gives one item next cycle.
// Synchronous active-low reset clears head pointer, count and flags; RAM is not cleared.
`default_nettype none

module reversible_deque_drop_engine #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned VALUE_BITS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rdd_in_if.sink     i_item,
    rdd_out_if.source  o_res
);
    import rdd_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    // Pointer helpers, modulo DEPTH
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] res;
        res = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return res;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] res;
        res = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
        return res;
    endfunction

    // Sum below twice DEPTH, folded back with one compare and subtract
    function automatic logic [AW-1:0] ptr_fold(input logic [SW-1:0] s);
        logic [SW-1:0] res;
        res = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return res[AW-1:0];
    endfunction

    // Control state
    t_state          r_state, n_state;
    logic [AW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic            r_rev;
    logic            r_err;
    logic            r_ovf;

    // Drain pipeline
    logic [AW-1:0]   r_rptr;
    logic [CW-1:0]   r_left;
    logic            r_dir;
    logic            r_rdv;
    logic            r_rd_last;

    // Output register
    logic            r_out_valid;
    t_status         r_out_status;
    logic [VAL_W-1:0] r_out_value;
    logic            r_out_last;

    // RAM ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic            item_rdy;
    logic            acc;
    logic            out_free;
    logic            out_load;
    logic            fin_single;
    logic            fin_drain;
    t_status         fin_status;
    logic [AW-1:0]   tail_ptr;
    logic [AW-1:0]   back_ptr;

    rdd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    // Handshake and decode
    assign out_free   = !r_out_valid || o_res.ready;
    assign acc        = i_item.valid && item_rdy;
    assign out_load   = (r_state == S_DRAIN) && r_rdv && out_free;
    assign tail_ptr   = ptr_fold(SW'(r_head) + SW'(r_count));
    assign back_ptr   = ptr_fold(SW'(r_head) + SW'(r_count) - SW'(1));
    assign fin_drain  = (i_item.func == FN_FINISH) && !r_err && !r_ovf && (r_count != '0);
    assign fin_single = (i_item.func == FN_FINISH) && !fin_drain;

    always_comb begin
        if (r_err) begin
            fin_status = ST_ERROR;
        end else if (r_ovf) begin
            fin_status = ST_OVERFLOW;
        end else begin
            fin_status = ST_EMPTY;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && fin_drain) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (out_load && r_rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: item ready, RAM write and read enables
    always_comb begin
        item_rdy  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = tail_ptr;
        ram_wdata = VALUE_BITS'(i_item.value);
        case (r_state)
            S_IDLE: begin
                item_rdy = out_free;
                ram_we   = acc && (i_item.func == FN_PUSH) && (r_count != CW'(DEPTH));
            end
            S_DRAIN: begin
                ram_re = (r_left != '0) && (!r_rdv || out_load);
            end
            default: begin
                item_rdy = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_err       <= 1'b0;
            r_ovf       <= 1'b0;
            r_left      <= '0;
            r_rdv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Command handling
            if (acc) begin
                case (i_item.func)
                    FN_PUSH: begin
                        if (r_count == CW'(DEPTH)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    FN_REVERSE: begin
                        r_rev <= !r_rev;
                    end
                    FN_DROP: begin
                        if (r_count == '0) begin
                            r_err <= 1'b1;
                        end else begin
                            if (!r_rev) begin
                                r_head <= ptr_inc(r_head);
                            end
                            r_count <= r_count - CW'(1);
                        end
                    end
                    FN_FINISH: begin
                        if (fin_drain) begin
                            r_left <= r_count;
                        end
                        r_head  <= '0;
                        r_count <= '0;
                        r_rev   <= 1'b0;
                        r_err   <= 1'b0;
                        r_ovf   <= 1'b0;
                    end
                    default: begin
                        r_rev <= r_rev;
                    end
                endcase
            end

            // Drain read issue and read-data slot
            if (ram_re) begin
                r_left <= r_left - CW'(1);
                r_rdv  <= 1'b1;
            end else if (out_load) begin
                r_rdv <= 1'b0;
            end

            // Output register valid
            if ((acc && fin_single) || out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (acc && fin_drain) begin
            r_dir  <= r_rev;
            r_rptr <= r_rev ? back_ptr : r_head;
        end else if (ram_re) begin
            r_rptr <= r_dir ? ptr_dec(r_rptr) : ptr_inc(r_rptr);
        end
        if (ram_re) begin
            r_rd_last <= (r_left == CW'(1));
        end
        if (acc && fin_single) begin
            r_out_status <= fin_status;
            r_out_value  <= '0;
            r_out_last   <= 1'b1;
        end else if (out_load) begin
            r_out_status <= ST_VALID;
            r_out_value  <= VAL_W'(ram_rdata);
            r_out_last   <= r_rd_last;
        end
    end

    assign i_item.ready    = item_rdy;
    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.value_res = r_out_value;
    assign o_res.last      = r_out_last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above depth");

    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("store write during drain");

    a_rdv_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdv |-> (r_state == S_DRAIN))
        else $error("read data pending outside drain");

    a_drain_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> ((r_left != '0) || r_rdv))
        else $error("drain stalled with nothing left");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_rd_last) |=> (r_state == S_IDLE) && r_out_valid && r_out_last)
        else $error("final drain item did not end the drain");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the reversible deque drop engine.
// Drives command items, predicts each result item in a local model of the deque, compares.
// Depends on rdd_pkg, rdd_if and the engine RTL.
`default_nettype none

module tb_top;
    import rdd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned DRAIN_LIMIT = 200000;

    // Expected result item
    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] value_res;
        logic             last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    rdd_in_if  item_if ();
    rdd_out_if res_if ();

    reversible_deque_drop_engine #(
        .DEPTH      (STORE_DEPTH),
        .VALUE_BITS (VAL_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if.sink),
        .o_res   (res_if.source)
    );

    // Local copy of the deque state
    logic [VAL_W-1:0] deque_mem [STORE_DEPTH];
    logic [5:0]       deque_head;
    int unsigned      deque_count;
    logic             deque_reversed;
    logic             deque_err;
    logic             deque_ovf;

    t_result     pending_results[$];
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned recv_hold;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    // Apply one accepted command to the local deque and queue its results
    task automatic deque_apply(input t_func fn, input logic [VAL_W-1:0] val);
        t_result     r;
        int unsigned i;
        logic [5:0]  pos;
        case (fn)
            FN_PUSH: begin
                if (deque_count >= STORE_DEPTH) begin
                    deque_ovf = 1'b1;
                end else begin
                    pos = deque_head + 6'(deque_count);
                    deque_mem[pos] = val;
                    deque_count++;
                end
            end
            FN_REVERSE: begin
                deque_reversed = ~deque_reversed;
            end
            FN_DROP: begin
                if (deque_count == 0) begin
                    deque_err = 1'b1;
                end else begin
                    if (!deque_reversed) deque_head = deque_head + 6'd1;
                    deque_count--;
                end
            end
            default: begin
                r.value_res = '0;
                r.last      = 1'b1;
                if (deque_err) begin
                    r.status = ST_ERROR;
                    pending_results.push_back(r);
                end else if (deque_ovf) begin
                    r.status = ST_OVERFLOW;
                    pending_results.push_back(r);
                end else if (deque_count == 0) begin
                    r.status = ST_EMPTY;
                    pending_results.push_back(r);
                end else begin
                    for (i = 0; i < deque_count; i++) begin
                        pos = deque_reversed ? deque_head + 6'(deque_count - 1 - i)
                                             : deque_head + 6'(i);
                        r.status    = ST_VALID;
                        r.value_res = deque_mem[pos];
                        r.last      = (i + 1 == deque_count);
                        pending_results.push_back(r);
                    end
                end
                deque_head     = '0;
                deque_count    = 0;
                deque_reversed = 1'b0;
                deque_err      = 1'b0;
                deque_ovf      = 1'b0;
            end
        endcase
    endtask

    // Offer one item, with random gaps before it, and wait for acceptance
    task automatic send_item(input t_func fn, input logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.func  <= fn;
        item_if.value <= val;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        deque_apply(fn, val);
        items_sent++;
    endtask

    task automatic push_rand();
        send_item(FN_PUSH, VAL_W'($urandom_range(0, 255)));
    endtask

    // Stop sending until every expected result is in, then let the block settle
    task automatic wait_drained();
        int unsigned n;
        n = 0;
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stalls plus an optional long hold-off
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (recv_hold > 0) begin
                res_if.ready <= 1'b0;
                recv_hold--;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $display({"%0t ERROR unexpected result: expected none, ",
                          "actual status %0d value %0d last %0d"},
                         $time, res_if.status, res_if.value_res, res_if.last);
                fail_count++;
            end else begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                if (res_if.status !== exp_r.status) begin
                    $display("%0t ERROR status: expected %0d actual %0d",
                             $time, exp_r.status, res_if.status);
                    fail_count++;
                end
                if (res_if.value_res !== exp_r.value_res) begin
                    $display("%0t ERROR value_res: expected %0d actual %0d",
                             $time, exp_r.value_res, res_if.value_res);
                    fail_count++;
                end
                if (res_if.last !== exp_r.last) begin
                    $display("%0t ERROR last: expected %0d actual %0d",
                             $time, exp_r.last, res_if.last);
                    fail_count++;
                end
            end
        end
    end

    // Extremes, each function and each corner case on short lists
    task automatic test_directed();
        send_item(FN_FINISH, 8'd0);     // empty store
        send_item(FN_PUSH, 8'h00);      // zero value kept
        send_item(FN_PUSH, 8'hFF);
        send_item(FN_PUSH, 8'hA5);
        send_item(FN_FINISH, 8'hFF);
        send_item(FN_PUSH, 8'd1);       // reversed drain
        send_item(FN_PUSH, 8'd2);
        send_item(FN_PUSH, 8'd3);
        send_item(FN_REVERSE, 8'h5A);
        send_item(FN_FINISH, 8'd0);
        send_item(FN_PUSH, 8'd4);       // drop from the front
        send_item(FN_PUSH, 8'd5);
        send_item(FN_DROP, 8'hFF);
        send_item(FN_FINISH, 8'd0);
        send_item(FN_PUSH, 8'd6);       // drop from the back
        send_item(FN_PUSH, 8'd7);
        send_item(FN_REVERSE, 8'd0);
        send_item(FN_DROP, 8'd0);
        send_item(FN_FINISH, 8'd0);
        send_item(FN_DROP, 8'd0);       // drop on empty, later push ignored by finish
        send_item(FN_PUSH, 8'd8);
        send_item(FN_FINISH, 8'd0);
        wait_drained();
    endtask

    // Full store: long output stall, wrap-around, overflow, error over overflow
    task automatic test_full_store();
        int k;
        recv_hold = 300;
        for (k = 0; k < STORE_DEPTH; k++) push_rand();
        send_item(FN_FINISH, 8'd0);
        // these back up behind the stalled drain
        for (k = 0; k < STORE_DEPTH; k++) push_rand();
        for (k = 0; k < 3; k++) send_item(FN_DROP, 8'd0);
        for (k = 0; k < 3; k++) push_rand();
        send_item(FN_REVERSE, 8'd0);
        send_item(FN_FINISH, 8'd0);
        for (k = 0; k <= STORE_DEPTH; k++) push_rand();
        send_item(FN_FINISH, 8'd0);
        send_item(FN_DROP, 8'd0);
        for (k = 0; k <= STORE_DEPTH; k++) push_rand();
        send_item(FN_FINISH, 8'd0);
        wait_drained();
    endtask

    // Mostly well-formed command sequences ending in finish, some noise
    task automatic test_random(input int unsigned n_items);
        int unsigned start;
        int unsigned len;
        int unsigned k;
        int unsigned r;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66)
                                                  : $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        send_item(FN_REVERSE, VAL_W'($urandom_range(0, 255)));
                    else if (r < 35 && deque_count > 0)
                        send_item(FN_DROP, VAL_W'($urandom_range(0, 255)));
                    else
                        push_rand();
                end
                send_item(FN_FINISH, VAL_W'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    send_item(t_func'($urandom_range(0, 3)), VAL_W'($urandom_range(0, 255)));
            end
        end
        wait_drained();
    endtask

    // Main sequence
    initial begin
        int unsigned n;
        i_rst_n        <= 1'b0;
        item_if.valid  <= 1'b0;
        item_if.func   <= FN_PUSH;
        item_if.value  <= '0;
        fail_count     = 0;
        items_sent     = 0;
        send_idle_pct  = 16;
        recv_idle_pct  = 49;
        recv_hold      = 0;
        deque_head     = '0;
        deque_count    = 0;
        deque_reversed = 1'b0;
        deque_err      = 1'b0;
        deque_ovf      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_random(40);
        send_idle_pct = 49;
        recv_idle_pct = 16;
        test_random(40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(40);

        n = 0;
        while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t ERROR %0d expected results never arrived",
                     $time, pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
